### rtl/olsp_pkg.sv
// ============================================================================
// olsp_pkg
// Shared types and constants for the open-loop sine PWM modulator.
// ============================================================================
`default_nettype none

package olsp_pkg;

    // Sine table geometry and phase accumulator width.
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;
    localparam int TABLE_AW         = $clog2(SINE_TABLE_DEPTH);
    localparam int T_SHIFT          = 16 - TABLE_AW;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_FALLBACK  = 3'd5;

    // Register reset values.
    localparam logic [31:0] RST_PHASE_STEP    = 32'd21474836;
    localparam logic [14:0] RST_CURRENT_LIMIT = 15'd2048;
    localparam logic [15:0] RST_DUTY_FLOOR    = 16'd6554;
    localparam logic [15:0] RST_DUTY_CEILING  = 16'd58982;
    localparam logic [15:0] RST_FILTER_GAIN   = 16'd65;
    localparam logic [15:0] RST_BUS_FALLBACK  = 16'd5120;

    // Converter modes.
    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_POWER = 2'd1,
        RUN_ERROR = 2'd2
    } t_run_state;

    // Quarter-wave sine polynomial (Horner, Q30, truncating shifts).
    localparam logic [31:0] POLY_SEED = 32'd172272;
    localparam int          POLY_TERMS = 4;
    typedef logic [31:0] t_coef_arr [POLY_TERMS];
    localparam t_coef_arr POLY_COEF = '{
        32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    localparam logic [15:0] SINE_MAX  = 16'd32767;
    localparam logic [15:0] DUTY_MID  = 16'd32768;
    localparam logic [15:0] ONE_VOLT  = 16'd256;

    // Divider sizing: amplitude (13 bits) times sine magnitude (15 bits).
    localparam int DIV_NUM_W = 28;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Multiplier: 32 x 16 unsigned, registered.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_in;
        logic       filt_mul;
        logic       filt_upd;
        logic       t2_load;
        logic       h_mul;
        logic       h_sub;
        logic [1:0] h_idx;
        logic       t_mul;
        logic       sine_rnd;
        logic       amp_mul;
        logic       div_start;
        logic       out_load;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic div_busy;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/olsp_div.sv
// ============================================================================
// olsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module olsp_div
    import olsp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [DIV_NUM_W-1:0]  i_num,
    input  wire [DIV_DEN_W-1:0]  i_den,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;
    logic [DIV_DEN_W:0]   rem_sub;

    assign rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

### rtl/olsp_dp.sv
// ============================================================================
// olsp_dp
// Datapath: config registers, held samples, bus filter, sine polynomial,
// shared multiplier, divider and output register.
// ============================================================================
`default_nettype none

module olsp_dp
    import olsp_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [S_DATA_W-1:0]    i_s_tdata,
    input  t_dp_cmd               i_cmd,
    input  wire                   i_m_tready,
    output logic                  o_m_tvalid,
    output logic [M_DATA_W-1:0]   o_m_tdata,
    output t_dp_stat              o_stat
);

    // Config registers.
    logic [31:0]           r_phase_step;
    logic [14:0]           r_cur_lim;
    logic [15:0]           r_duty_floor;
    logic [15:0]           r_duty_ceil;
    logic [15:0]           r_gain;
    logic [15:0]           r_fallback;

    // Tick state.
    logic [PHASE_BITS-1:0] r_phase;
    logic [15:0]           r_held1;
    logic [15:0]           r_held2;
    logic [15:0]           r_hbus;
    logic [31:0]           r_acc;
    t_run_state            r_run;
    logic [12:0]           r_amp;
    logic                  r_req;

    // Work registers.
    logic [PROD_W-1:0]     r_prod;
    logic [15:0]           r_t2;
    logic [31:0]           r_p;
    logic [15:0]           r_sine;
    logic [15:0]           r_den;
    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_out_data;

    // ---- sample latch ----
    logic [15:0] in_leg1, in_leg2, in_bus;
    logic        in_v1, in_v2, in_vb, in_req;
    logic [12:0] in_amp;

    assign in_leg1 = i_s_tdata[15:0];
    assign in_v1   = i_s_tdata[16];
    assign in_leg2 = i_s_tdata[32:17];
    assign in_v2   = i_s_tdata[33];
    assign in_bus  = i_s_tdata[49:34];
    assign in_vb   = i_s_tdata[50];
    assign in_amp  = i_s_tdata[63:51];
    assign in_req  = i_s_tdata[64];

    // ---- bus filter ----
    logic [31:0] target, fmag;
    logic        fneg;
    logic [15:0] filt;

    assign target = {r_hbus, 16'h0000};
    assign fneg   = target < r_acc;
    assign fmag   = fneg ? (r_acc - target) : (target - r_acc);
    assign filt   = r_acc[31:16];

    // ---- mode update and overcurrent ----
    function automatic logic over_limit(input logic [15:0] c, input logic [14:0] lim);
        logic signed [16:0] c17;
        logic signed [16:0] l17;
        c17 = {c[15], c};
        l17 = {2'b00, lim};
        return (c17 > l17) || (c17 < -l17);
    endfunction

    t_run_state n_run;
    always_comb begin
        n_run = r_run;
        if (r_run == RUN_IDLE) begin
            if (r_req) n_run = RUN_POWER;
        end else if (!r_req) begin
            n_run = RUN_IDLE;
        end else if (r_run != RUN_POWER) begin
            n_run = RUN_ERROR;
        end
        if (over_limit(r_held1, r_cur_lim) || over_limit(r_held2, r_cur_lim)) begin
            n_run = RUN_ERROR;
        end
    end

    // ---- sine index ----
    logic [1:0]          quad;
    logic [TABLE_AW-1:0] idx;
    logic [TABLE_AW:0]   k;
    logic [15:0]         t_arg;

    assign quad  = r_phase[PHASE_BITS-1 -: 2];
    assign idx   = r_phase[PHASE_BITS-3 -: TABLE_AW];
    assign k     = quad[0] ? ((TABLE_AW+1)'(SINE_TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
    assign t_arg = 16'({k[TABLE_AW-1:0], T_SHIFT'(0)});

    // ---- shared multiplier ----
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [15:0]        sine_mag;

    assign sine_mag = r_sine[15] ? (16'h0000 - r_sine) : r_sine;

    always_comb begin
        mul_a = 32'(t_arg);
        mul_b = t_arg;
        priority if (i_cmd.filt_mul) begin
            mul_a = fmag;
            mul_b = r_gain;
        end else if (i_cmd.h_mul) begin
            mul_a = r_p;
            mul_b = r_t2;
        end else if (i_cmd.t_mul) begin
            mul_a = r_p;
            mul_b = t_arg;
        end else if (i_cmd.amp_mul) begin
            mul_a = 32'(sine_mag);
            mul_b = 16'(r_amp);
        end else begin
            mul_a = 32'(t_arg);
            mul_b = t_arg;
        end
    end

    // ---- rounding of polynomial ----
    logic [31:0] s_raw;
    logic [32:0] s_rnd;
    logic [15:0] s_mag;

    assign s_raw = r_prod[47:16];
    assign s_rnd = ({1'b0, s_raw} + 33'd16384) >> 15;
    always_comb begin
        if (k[TABLE_AW] || (s_rnd > 33'(SINE_MAX))) s_mag = SINE_MAX;
        else                                         s_mag = s_rnd[15:0];
    end

    // ---- divider ----
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] quo;
    logic [15:0]          den_sel;

    assign den_sel = (filt > ONE_VOLT) ? filt : r_fallback;

    olsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod[DIV_NUM_W-1:0]),
        .i_den   (den_sel),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // ---- duties ----
    logic               num_nz;
    logic [31:0]        off_mag;
    logic signed [31:0] off, sum1, sum2, d1c, d2c, flo, ceil;
    logic               en;
    logic [15:0]        duty1, duty2;

    assign num_nz  = r_prod != '0;
    assign off_mag = (r_den == '0) ? (num_nz ? 32'h1000_0000 : 32'h0) : 32'(quo);
    assign off     = r_sine[15] ? -$signed(off_mag) : $signed(off_mag);
    assign sum1    = $signed(32'(DUTY_MID)) + off;
    assign sum2    = $signed(32'(DUTY_MID)) - off;
    assign flo     = $signed(32'(r_duty_floor));
    assign ceil    = $signed(32'(r_duty_ceil));
    assign d1c     = (sum1 > ceil) ? ceil : ((sum1 < flo) ? flo : sum1);
    assign d2c     = (sum2 > ceil) ? ceil : ((sum2 < flo) ? flo : sum2);
    assign en      = r_run == RUN_POWER;
    assign duty1   = en ? d1c[15:0] : 16'h0000;
    assign duty2   = en ? d2c[15:0] : 16'h0000;

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_cur_lim    <= RST_CURRENT_LIMIT;
            r_duty_floor <= RST_DUTY_FLOOR;
            r_duty_ceil  <= RST_DUTY_CEILING;
            r_gain       <= RST_FILTER_GAIN;
            r_fallback   <= RST_BUS_FALLBACK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PHASE_STEP:    r_phase_step <= i_cfg_data;
                CFG_CURRENT_LIMIT: r_cur_lim    <= i_cfg_data[14:0];
                CFG_DUTY_FLOOR:    r_duty_floor <= i_cfg_data[15:0];
                CFG_DUTY_CEILING:  r_duty_ceil  <= i_cfg_data[15:0];
                CFG_FILTER_GAIN:   r_gain       <= i_cfg_data[15:0];
                CFG_BUS_FALLBACK:  r_fallback   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_held1     <= '0;
            r_held2     <= '0;
            r_hbus      <= '0;
            r_acc       <= '0;
            r_run       <= RUN_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                if (in_v1) r_held1 <= in_leg1;
                if (in_v2) r_held2 <= in_leg2;
                if (in_vb) r_hbus  <= in_bus;
                r_phase <= r_phase + r_phase_step[PHASE_BITS-1:0];
            end
            if (i_cmd.filt_mul) r_run <= n_run;
            if (i_cmd.filt_upd) begin
                r_acc <= fneg ? (r_acc - r_prod[47:16]) : (r_acc + r_prod[47:16]);
            end
            if (i_cmd.out_load)      r_out_valid <= 1'b1;
            else if (i_m_tready)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_amp <= in_amp;
            r_req <= in_req;
        end
        if (i_cmd.filt_mul || i_cmd.filt_upd || i_cmd.h_mul || i_cmd.t_mul
            || i_cmd.amp_mul) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.t2_load) begin
            r_t2 <= r_prod[31:16];
            r_p  <= POLY_SEED;
        end
        if (i_cmd.h_sub)     r_p    <= POLY_COEF[i_cmd.h_idx] - r_prod[47:16];
        if (i_cmd.sine_rnd)  r_sine <= quad[1] ? (16'h0000 - s_mag) : s_mag;
        if (i_cmd.div_start) r_den  <= den_sel;
        if (i_cmd.out_load) begin
            r_out_data <= {5'b0, filt, r_sine, r_run, en, duty2, duty1};
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_data;
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_busy = r_out_valid && !i_m_tready;

endmodule

`default_nettype wire

### rtl/olsp_ctrl.sv
// ============================================================================
// olsp_ctrl
// Sequencer for one control tick: filter, polynomial, product, divide, emit.
// ============================================================================
`default_nettype none

module olsp_ctrl
    import olsp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FMUL, ST_FUPD, ST_T2, ST_HMUL, ST_HSUB,
        ST_TMUL, ST_RND, ST_AMUL, ST_DSTART, ST_DWAIT, ST_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE:   if (i_s_tvalid) r_state <= ST_FMUL;
                ST_FMUL:   r_state <= ST_FUPD;
                ST_FUPD:   r_state <= ST_T2;
                ST_T2: begin
                    r_cnt   <= '0;
                    r_state <= ST_HMUL;
                end
                ST_HMUL:   r_state <= ST_HSUB;
                ST_HSUB: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'(POLY_TERMS - 1)) r_state <= ST_TMUL;
                    else                             r_state <= ST_HMUL;
                end
                ST_TMUL:   r_state <= ST_RND;
                ST_RND:    r_state <= ST_AMUL;
                ST_AMUL:   r_state <= ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT:  if (!i_stat.div_busy) r_state <= ST_DONE;
                ST_DONE:   if (!i_stat.out_busy) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.h_idx     = r_cnt;
        o_cmd.load_in   = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.filt_mul  = r_state == ST_FMUL;
        o_cmd.filt_upd  = r_state == ST_FUPD;
        o_cmd.t2_load   = r_state == ST_T2;
        o_cmd.h_mul     = r_state == ST_HMUL;
        o_cmd.h_sub     = r_state == ST_HSUB;
        o_cmd.t_mul     = r_state == ST_TMUL;
        o_cmd.sine_rnd  = r_state == ST_RND;
        o_cmd.amp_mul   = r_state == ST_AMUL;
        o_cmd.div_start = r_state == ST_DSTART;
        o_cmd.out_load  = (r_state == ST_DONE) && !i_stat.out_busy;
    end

    assign o_s_tready = r_state == ST_IDLE;

endmodule

`default_nettype wire

### rtl/open_loop_sine_pwm_modulator.sv
// ============================================================================
// open_loop_sine_pwm_modulator
// Open-loop sine PWM modulator with filtered bus-voltage feedforward.
// ============================================================================
// One input transaction is one control tick and yields one output
// transaction. After acceptance, a tick is sequenced on the shared 32x16
// multiplier (bus filter, Horner sine polynomial, amplitude product) up to
// the divider start, waits on the restoring divider of amplitude*sine/bus
// for its done status, and then loads the output register. The input is
// ready again the cycle after that load. One tick is in flight at a time;
// a finished result sits in the output register, so the next tick may be
// accepted while it waits, and that tick stalls before its own output
// load until the register is free. Configuration writes are always ready
// and take effect at once; write them only between ticks.
`default_nettype none

module open_loop_sine_pwm_modulator
    import olsp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // config write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    // tick input stream
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: leg1_current[15:0], leg1_current_valid[16], leg2_current[32:17],
    //        leg2_current_valid[33], bus_voltage[49:34], bus_voltage_valid[50],
    //        amplitude[63:51], run_request[64], zero pad [71:65]
    input  wire [S_DATA_W-1:0]   i_s_tdata,
    // result output stream
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    // tdata: duty_leg1[15:0], duty_leg2[31:16], outputs_enabled[32],
    //        converter_state[34:33], sine_value[50:35], filtered_bus[66:51],
    //        zero pad [71:67]
    output logic [M_DATA_W-1:0]  o_m_tdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer: one tick at a time
    olsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, state and output register
    olsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

### rtl/olsp_checker.sv
// ============================================================================
// olsp_checker
// Port-level checks for the modulator, bound to the top level.
// ============================================================================
`default_nettype none

module olsp_checker
    import olsp_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_s_tvalid,
    input wire                o_s_tready,
    input wire                o_m_tvalid,
    input wire                i_m_tready,
    input wire [M_DATA_W-1:0] o_m_tdata
);

    // a result waiting for the sink stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    // enable flag agrees with the reported mode
    a_en_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[32] == (o_m_tdata[34:33] == RUN_POWER)))
        else $error("enable flag disagrees with mode");

    // duties are zero when the bridge is off
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[32] |-> (o_m_tdata[31:0] == 32'h0))
        else $error("nonzero duty with outputs off");

    // one tick in flight: no acceptance right after an acceptance
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second tick accepted back to back");

endmodule

bind open_loop_sine_pwm_modulator olsp_checker u_olsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

### test/pwm_tick_checker.sv
// ============================================================================
// pwm_tick_checker
// Watches the tick, result and register channels of the sine PWM modulator,
// predicts each result from its own copy of the modulator state and compares
// it field by field against what the block delivers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwm_tick_checker
    import olsp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire                  i_cfg_ready,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_s_tvalid,
    input  wire                  i_s_tready,
    input  wire [S_DATA_W-1:0]   i_s_tdata,
    input  wire                  i_m_tvalid,
    input  wire                  i_m_tready,
    input  wire [M_DATA_W-1:0]   i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [15:0] quarter_lut [SINE_TABLE_DEPTH];

    // register shadow
    logic [31:0] step_r;
    logic [14:0] limit_r;
    logic [15:0] floor_r, ceil_r, gain_r, fallback_r;

    // modulator state shadow
    logic [31:0] phase;
    logic [15:0] cur1, cur2, bus_hold;
    logic [31:0] bus_acc;
    t_run_state  mode;

    logic [M_DATA_W-1:0] duty_expect_q [$];

    function automatic logic [15:0] poly_sine(input logic [63:0] t);
        logic [63:0] t2, p, s;
        t2 = (t * t) >> 16;
        p  = 64'd172272;
        p  = 64'd5026995    - ((t2 * p) >> 16);
        p  = 64'd85569306   - ((t2 * p) >> 16);
        p  = 64'd693598668  - ((t2 * p) >> 16);
        p  = 64'd1686629713 - ((t2 * p) >> 16);
        s  = (t * p) >> 16;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) s = 64'd32767;
        return s[15:0];
    endfunction

    initial begin
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            quarter_lut[i] = poly_sine((64'(i) << 16) / SINE_TABLE_DEPTH);
    end

    function automatic logic trips(input logic [15:0] held);
        int c, lim;
        c   = int'($signed(held));
        lim = int'(limit_r);
        return (c > lim) || (c < -lim);
    endfunction

    function automatic longint clamp_duty(input longint v);
        if (v > longint'(ceil_r)) return longint'(ceil_r);
        if (v < longint'(floor_r)) return longint'(floor_r);
        return v;
    endfunction

    // one control tick: updates the shadow state, returns the packed result
    task automatic predict_tick(input logic [S_DATA_W-1:0] d,
                                output logic [M_DATA_W-1:0] r);
        logic [63:0] target, diff, step_amt, n;
        logic        below, req, en;
        logic [15:0] filt;
        logic [1:0]  quad;
        logic [10:0] k;
        int          sine;
        logic [12:0] amp;
        longint      num, off;
        logic [31:0] den;
        logic [15:0] du1, du2;
        req = d[64];
        amp = d[63:51];
        if (d[16]) cur1 = d[15:0];
        if (d[33]) cur2 = d[32:17];
        if (d[50]) bus_hold = d[49:34];

        // low-pass: acc += sign(d) * floor(|d| * alpha / 2^16)
        target   = 64'(bus_hold) << 16;
        below    = target < 64'(bus_acc);
        diff     = below ? 64'(bus_acc) - target : target - 64'(bus_acc);
        step_amt = (diff * 64'(gain_r)) >> 16;
        bus_acc  = below ? bus_acc - step_amt[31:0] : bus_acc + step_amt[31:0];
        filt     = bus_acc[31:16];

        if (mode == RUN_IDLE) begin
            if (req) mode = RUN_POWER;
        end else if (!req) begin
            mode = RUN_IDLE;
        end else if (mode != RUN_POWER) begin
            mode = RUN_ERROR;
        end

        phase = phase + step_r;
        quad  = phase[31:30];
        k     = quad[0] ? 11'd1024 - {1'b0, phase[29:20]} : {1'b0, phase[29:20]};
        sine  = (k >= 11'd1024) ? 32767 : int'(quarter_lut[k[9:0]]);
        if (quad[1]) sine = -sine;

        if (trips(cur1) || trips(cur2)) mode = RUN_ERROR;

        en  = (mode == RUN_POWER);
        du1 = '0;
        du2 = '0;
        if (en) begin
            num = longint'(amp) * longint'(sine);
            den = (filt > ONE_VOLT) ? 32'(filt) : 32'(fallback_r);
            if (den == 0) begin
                // no divisor at all: full-scale offset by sign of the product
                off = (num > 0) ? (64'sd1 <<< 28) : ((num < 0) ? -(64'sd1 <<< 28) : 0);
            end else begin
                n   = (num < 0) ? 64'(-num) : 64'(num);
                off = longint'(n / 64'(den));
                if (num < 0) off = -off;
            end
            du1 = 16'(clamp_duty(32768 + off));
            du2 = 16'(clamp_duty(32768 - off));
        end
        r = '0;
        r[15:0]  = du1;
        r[31:16] = du2;
        r[32]    = en;
        r[34:33] = mode;
        r[50:35] = 16'(sine);
        r[66:51] = filt;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        logic [M_DATA_W-1:0] res, want;
        if (!i_rst_n) begin
            step_r     = RST_PHASE_STEP;
            limit_r    = RST_CURRENT_LIMIT;
            floor_r    = RST_DUTY_FLOOR;
            ceil_r     = RST_DUTY_CEILING;
            gain_r     = RST_FILTER_GAIN;
            fallback_r = RST_BUS_FALLBACK;
            phase      = '0;
            cur1       = '0;
            cur2       = '0;
            bus_hold   = '0;
            bus_acc    = '0;
            mode       = RUN_IDLE;
            duty_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP:    step_r     = i_cfg_data;
                    CFG_CURRENT_LIMIT: limit_r    = i_cfg_data[14:0];
                    CFG_DUTY_FLOOR:    floor_r    = i_cfg_data[15:0];
                    CFG_DUTY_CEILING:  ceil_r     = i_cfg_data[15:0];
                    CFG_FILTER_GAIN:   gain_r     = i_cfg_data[15:0];
                    CFG_BUS_FALLBACK:  fallback_r = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_tick(i_s_tdata, res);
                duty_expect_q.push_back(res);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (duty_expect_q.size() == 0) begin
                    $display("%0t: result with none expected, got %h", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = duty_expect_q.pop_front();
                    check_field("duty_leg1", want[15:0], i_m_tdata[15:0]);
                    check_field("duty_leg2", want[31:16], i_m_tdata[31:16]);
                    check_field("outputs_enabled", want[32], i_m_tdata[32]);
                    check_field("converter_state", want[34:33], i_m_tdata[34:33]);
                    check_field("sine_value", want[50:35], i_m_tdata[50:35]);
                    check_field("filtered_bus", want[66:51], i_m_tdata[66:51]);
                    check_field("pad", want[71:67], i_m_tdata[71:67]);
                end
            end
        end
        o_pending <= duty_expect_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

`default_nettype wire

### test/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the open-loop sine PWM modulator.
// ============================================================================
// Directed ticks hit the field extremes, the overcurrent trip, error
// clearing and mode changes; then random ticks run under several register
// settings, including crossed duty limits, zero divisor and phase extremes.
// Both stream sides idle at random; one long output hold-off backs the
// block up. The checker module predicts and compares every result.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import olsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [S_DATA_W-1:0]   s_data;
    logic                  m_valid;
    logic                  m_ready;
    logic [M_DATA_W-1:0]   m_data;
    int                    fail_count;
    int                    pending;
    int                    cycles;

    // stimulus controls for the sender and receiver
    logic steady;     // no gaps on either side
    logic hold_req;   // receiver does one long hold-off
    logic low_bus;    // bus samples near zero, for the fallback divisor

    open_loop_sine_pwm_modulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data)
    );

    pwm_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        if (steady) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_tick(
        input logic [15:0] c1, input logic v1, input logic [15:0] c2, input logic v2,
        input logic [15:0] bus, input logic vb, input logic [12:0] amp, input logic run);
        return {7'd0, run, amp, vb, bus, v2, c2, v1, c1};
    endfunction

    function automatic logic [15:0] rand_current();
        // mostly well inside the trip limit, sometimes anything at all
        if ($urandom_range(0, 15) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 1500) - 750);
    endfunction

    function automatic logic [S_DATA_W-1:0] rand_tick();
        logic [15:0] bus;
        if (low_bus)
            bus = 16'($urandom_range(0, 300));
        else if ($urandom_range(0, 7) == 0)
            bus = 16'($urandom);
        else
            bus = 16'($urandom_range(2048, 12800));
        return pack_tick(rand_current(), 1'($urandom), rand_current(), 1'($urandom),
                         bus, 1'($urandom), 13'($urandom_range(0, 7680)),
                         $urandom_range(0, 19) != 0);
    endfunction

    // offer one tick; valid stays up when the next one follows with no gap
    task automatic send_tick(input logic [S_DATA_W-1:0] d);
        int  gap;
        logic rdy;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do begin
            @(negedge i_clk);
            rdy = s_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge i_clk);
            rdy = cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    // quiesce: stop offering, let every result drain, then a latency margin
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] step, input logic [14:0] lim,
                                 input logic [15:0] flr, input logic [15:0] ceil,
                                 input logic [15:0] gain, input logic [15:0] fb);
        drain();
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_CURRENT_LIMIT, 32'(lim));
        write_reg(CFG_DUTY_FLOOR, 32'(flr));
        write_reg(CFG_DUTY_CEILING, 32'(ceil));
        write_reg(CFG_FILTER_GAIN, 32'(gain));
        write_reg(CFG_BUS_FALLBACK, 32'(fb));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++) begin
            // some stretches with no idling at all
            if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            send_tick(rand_tick());
        end
        steady = 1'b0;
    endtask

    // output side: random stall per result, one long hold-off on request
    initial begin
        int  stall;
        logic vld;
        m_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            if (hold_req) begin
                stall    = 400;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                vld = m_valid;
                @(posedge i_clk);
            end while (!vld);
        end
    end

    initial begin
        steady    = 1'b0;
        hold_req  = 1'b0;
        low_bus   = 1'b0;
        i_rst_n   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle ticks, power up, field extremes, trip and recovery
        send_tick(pack_tick(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 13'd0, 1'b0));
        send_tick(pack_tick(16'h0000, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 13'd7680, 1'b0));
        send_tick(pack_tick(16'h0100, 1'b1, 16'hFF00, 1'b1, 16'h1800, 1'b1, 13'd7680, 1'b1));
        send_tick(pack_tick(16'h0800, 1'b1, 16'hF800, 1'b1, 16'h1800, 1'b0, 13'd7680, 1'b1));
        send_tick(pack_tick(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 13'd0, 1'b1));
        // overcurrent just past the limit on each leg, then hold it
        send_tick(pack_tick(16'h0801, 1'b1, 16'h0000, 1'b0, 16'h3000, 1'b1, 13'd4000, 1'b1));
        send_tick(pack_tick(16'h0000, 1'b1, 16'hF7FF, 1'b1, 16'h3000, 1'b1, 13'd4000, 1'b1));
        send_tick(pack_tick(16'h0000, 1'b1, 16'h0000, 1'b1, 16'h3000, 1'b1, 13'd4000, 1'b1));
        // run request drop clears error, then power again
        send_tick(pack_tick(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h3000, 1'b1, 13'd4000, 1'b0));
        send_tick(pack_tick(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h3000, 1'b1, 13'd4000, 1'b1));
        // extreme currents on both legs
        send_tick(pack_tick(16'h7FFF, 1'b1, 16'h8000, 1'b1, 16'hFFFF, 1'b1, 13'd7680, 1'b1));
        send_tick(pack_tick(16'h8000, 1'b1, 16'h7FFF, 1'b1, 16'hFFFF, 1'b1, 13'd1, 1'b1));
        send_tick(pack_tick(16'h0000, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 13'h1FFF & 13'd7680,
                            1'b0));
        send_tick(pack_tick(16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 13'd0, 1'b1));
        for (int i = 0; i < 6; i++)
            send_tick(pack_tick(16'h00FF, 1'b1, 16'hFF01, 1'b1, 16'h0A00, 1'b1,
                                13'd7680, 1'b1));

        // writes beyond the register list must leave everything alone
        drain();
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0000_0000);
        cfg_valid <= 1'b0;

        // random at reset settings; long output hold-off partway through
        random_run(60);
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_tick(rand_tick());
        steady = 1'b0;
        random_run(60);

        // wide open limits, fastest filter
        apply_setting(32'h0123_4567, 15'd32767, 16'd0, 16'd65535, 16'd65535, 16'd5120);
        random_run(120);
        // largest step, zero trip limit, frozen filter
        apply_setting(32'hFFFF_FFFF, 15'd0, 16'd6554, 16'd58982, 16'd0, 16'd65535);
        random_run(80);
        // no phase motion, crossed duty limits, zero fallback with a low bus
        low_bus = 1'b1;
        apply_setting(32'd0, 15'd2048, 16'd40000, 16'd20000, 16'd30000, 16'd0);
        random_run(100);
        apply_setting(32'h0800_0000, 15'd4000, 16'd0, 16'd65535, 16'd65535, 16'd0);
        random_run(80);
        low_bus = 1'b0;
        for (int p = 0; p < 2; p++) begin
            apply_setting($urandom, 15'($urandom_range(256, 32767)),
                          16'($urandom_range(0, 30000)), 16'($urandom_range(35000, 65535)),
                          16'($urandom), 16'($urandom));
            random_run(150);
        end

        drain();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
